### hdl/bnf_pkg.sv
// ----------------------------------------------------------------------------
// bnf_pkg
// Shared types and constants for the batch-norm affine fold pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package bnf_pkg;

  localparam int unsigned QW      = 32;
  localparam int unsigned VARW    = 31;
  localparam int unsigned EPSW    = 16;
  localparam int unsigned TAGW    = 16;
  localparam int unsigned ROOTW   = 32;
  localparam int unsigned SQREMW  = 35;
  localparam int unsigned NUMW    = 56;
  localparam int unsigned QUOW    = 40;
  localparam int unsigned SQ_STEPS  = ROOTW;
  localparam int unsigned DIV_STEPS = QUOW;

  localparam logic [EPSW-1:0] EPS_RESET = 16'd1;
  localparam logic [QW-1:0]   Q_MAX     = 32'h7FFF_FFFF;
  localparam logic [QW-1:0]   Q_MIN     = 32'h8000_0000;
  localparam logic [QUOW-1:0] QUO_POS_LIM = 40'h00_7FFF_FFFF;
  localparam logic [QUOW-1:0] QUO_NEG_LIM = 40'h00_8000_0000;

  // Per-item data that rides alongside the root and divide stages.
  typedef struct packed {
    logic            gain_neg;
    logic            gain_pos;
    logic            zero_den;
    logic [QW-1:0]   offset;
    logic [QW-1:0]   mean;
    logic [TAGW-1:0] tag;
  } side_t;

endpackage

`default_nettype wire

### hdl/bnf_sqrt_stage.sv
// ----------------------------------------------------------------------------
// bnf_sqrt_stage
// One registered digit step of the integer square root.
// ----------------------------------------------------------------------------
`default_nettype none

module bnf_sqrt_stage import bnf_pkg::*; (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               en_i,
  input  wire               valid_i,
  input  side_t             side_i,
  input  wire [QW-1:0]      rad_i,
  input  wire [SQREMW-1:0]  rem_i,
  input  wire [ROOTW-1:0]   root_i,
  output logic              valid_o,
  output side_t             side_o,
  output logic [QW-1:0]     rad_o,
  output logic [SQREMW-1:0] rem_o,
  output logic [ROOTW-1:0]  root_o
);

  logic [SQREMW-1:0] cur;
  logic [SQREMW-1:0] trial;
  logic              ge;

  assign cur   = {rem_i[SQREMW-3:0], rad_i[QW-1:QW-2]};
  assign trial = {1'b0, root_i, 2'b01};
  assign ge    = (cur >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      rad_o  <= {rad_i[QW-3:0], 2'b00};
      rem_o  <= ge ? (cur - trial) : cur;
      root_o <= {root_i[ROOTW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

### hdl/bnf_div_stage.sv
// ----------------------------------------------------------------------------
// bnf_div_stage
// One registered restoring-division step, one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module bnf_div_stage import bnf_pkg::*; (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              en_i,
  input  wire              valid_i,
  input  side_t            side_i,
  input  wire [NUMW-1:0]   num_i,
  input  wire [ROOTW-1:0]  rem_i,
  input  wire [ROOTW-1:0]  den_i,
  input  wire [QUOW-1:0]   quo_i,
  output logic             valid_o,
  output side_t            side_o,
  output logic [NUMW-1:0]  num_o,
  output logic [ROOTW-1:0] rem_o,
  output logic [ROOTW-1:0] den_o,
  output logic [QUOW-1:0]  quo_o
);

  logic [ROOTW:0] cur;
  logic [ROOTW:0] diff;
  logic           ge;

  assign cur  = {rem_i, num_i[NUMW-1]};
  assign diff = cur - {1'b0, den_i};
  assign ge   = (cur >= {1'b0, den_i});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_o <= side_i;
      num_o  <= {num_i[NUMW-2:0], 1'b0};
      rem_o  <= ge ? diff[ROOTW-1:0] : cur[ROOTW-1:0];
      den_o  <= den_i;
      quo_o  <= {quo_i[QUOW-2:0], ge};
    end
  end

endmodule

`default_nettype wire

### hdl/batch_norm_affine_fold.sv
// ----------------------------------------------------------------------------
// batch_norm_affine_fold
// Folds per-channel batch-norm parameters into a multiplier/additive pair.
// ----------------------------------------------------------------------------
// Fully pipelined: one item per cycle while the output is not stalled. An
// item passes the 32-step square root chain and the 40-step divider chain,
// one bit per stage, followed by a 32x32 multiply, rounding and the
// saturating subtract. A stall on the output freezes the whole pipeline;
// in_ready_o drops only while the output register holds an item that is not
// taken. Epsilon is written on the cfg channel, which is always ready.
`default_nettype none

module batch_norm_affine_fold import bnf_pkg::*; (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire [EPSW-1:0]         cfg_data_i,
  input  wire                    in_valid_i,
  output logic                   in_ready_o,
  input  wire signed [QW-1:0]    gain_i,
  input  wire signed [QW-1:0]    offset_i,
  input  wire signed [QW-1:0]    running_mean_i,
  input  wire [VARW-1:0]         running_variance_i,
  input  wire [TAGW-1:0]         channel_tag_i,
  output logic                   out_valid_o,
  input  wire                    out_ready_i,
  output logic signed [QW-1:0]   multiplier_o,
  output logic signed [QW-1:0]   additive_o,
  output logic                   status_o,
  output logic [TAGW-1:0]        result_tag_o
);

  logic            en;
  logic [EPSW-1:0] eps_q;

  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eps_q <= EPS_RESET;
    end else if (cfg_valid_i) begin
      eps_q <= cfg_data_i;
    end
  end

  // Input stage
  logic          v0_q;
  side_t         side0_q;
  logic [QW-1:0] s0_q;
  logic [QW-1:0] gmag0_q;
  logic [QW-1:0] s_d;
  logic [QW-1:0] gmag_d;
  side_t         side_d;

  assign s_d    = {1'b0, running_variance_i} + {{(QW-EPSW){1'b0}}, eps_q};
  assign gmag_d = gain_i[QW-1] ? (~gain_i + 1'b1) : gain_i;

  always_comb begin
    side_d.gain_neg = gain_i[QW-1];
    side_d.gain_pos = !gain_i[QW-1] && (gain_i != '0);
    side_d.zero_den = (s_d == '0);
    side_d.offset   = offset_i;
    side_d.mean     = running_mean_i;
    side_d.tag      = channel_tag_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side0_q <= side_d;
      s0_q    <= s_d;
      gmag0_q <= gmag_d;
    end
  end

  // Square root chain; gain magnitude carried alongside
  logic              sq_v    [SQ_STEPS+1];
  side_t             sq_side [SQ_STEPS+1];
  logic [QW-1:0]     sq_rad  [SQ_STEPS+1];
  logic [SQREMW-1:0] sq_rem  [SQ_STEPS+1];
  logic [ROOTW-1:0]  sq_root [SQ_STEPS+1];
  logic [QW-1:0]     sq_gmag_q [SQ_STEPS+1];

  assign sq_v[0]      = v0_q;
  assign sq_side[0]   = side0_q;
  assign sq_rad[0]    = s0_q;
  assign sq_rem[0]    = '0;
  assign sq_root[0]   = '0;
  assign sq_gmag_q[0] = gmag0_q;

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    bnf_sqrt_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[i]),
      .side_i  (sq_side[i]),
      .rad_i   (sq_rad[i]),
      .rem_i   (sq_rem[i]),
      .root_i  (sq_root[i]),
      .valid_o (sq_v[i+1]),
      .side_o  (sq_side[i+1]),
      .rad_o   (sq_rad[i+1]),
      .rem_o   (sq_rem[i+1]),
      .root_o  (sq_root[i+1])
    );
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_gmag_q[i+1] <= sq_gmag_q[i];
      end
    end
  end

  // Divider setup: numerator = |gain| * 2^24 + r/2
  logic            vp_q;
  side_t           sidep_q;
  logic [NUMW-1:0] nump_q;
  logic [ROOTW-1:0] rootp_q;
  logic [NUMW-1:0] num_d;

  assign num_d = {sq_gmag_q[SQ_STEPS], 24'd0}
               + {{(NUMW-ROOTW+1){1'b0}}, sq_root[SQ_STEPS][ROOTW-1:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (en) begin
      vp_q <= sq_v[SQ_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sidep_q <= sq_side[SQ_STEPS];
      nump_q  <= num_d;
      rootp_q <= sq_root[SQ_STEPS];
    end
  end

  // Division chain
  logic             dv_v    [DIV_STEPS+1];
  side_t            dv_side [DIV_STEPS+1];
  logic [NUMW-1:0]  dv_num  [DIV_STEPS+1];
  logic [ROOTW-1:0] dv_rem  [DIV_STEPS+1];
  logic [ROOTW-1:0] dv_den  [DIV_STEPS+1];
  logic [QUOW-1:0]  dv_quo  [DIV_STEPS+1];

  assign dv_v[0]    = vp_q;
  assign dv_side[0] = sidep_q;
  assign dv_num[0]  = {nump_q[QUOW-1:0], {(NUMW-QUOW){1'b0}}};
  assign dv_rem[0]  = {{(ROOTW-(NUMW-QUOW)){1'b0}}, nump_q[NUMW-1:QUOW]};
  assign dv_den[0]  = rootp_q;
  assign dv_quo[0]  = '0;

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    bnf_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_v[j]),
      .side_i  (dv_side[j]),
      .num_i   (dv_num[j]),
      .rem_i   (dv_rem[j]),
      .den_i   (dv_den[j]),
      .quo_i   (dv_quo[j]),
      .valid_o (dv_v[j+1]),
      .side_o  (dv_side[j+1]),
      .num_o   (dv_num[j+1]),
      .rem_o   (dv_rem[j+1]),
      .den_o   (dv_den[j+1]),
      .quo_o   (dv_quo[j+1])
    );
  end

  // Multiplier select and saturation
  logic          vm_q;
  side_t         sidem_q;
  logic [QW-1:0] m_q;
  logic          failm_q;
  logic [QW-1:0] m_d;
  logic          failm_d;
  logic [QUOW-1:0] quo;
  side_t         sdv;

  assign quo = dv_quo[DIV_STEPS];
  assign sdv = dv_side[DIV_STEPS];

  always_comb begin
    m_d     = quo[QW-1:0];
    failm_d = 1'b0;
    if (sdv.zero_den) begin
      failm_d = 1'b1;
      m_d     = sdv.gain_pos ? Q_MAX : (sdv.gain_neg ? Q_MIN : '0);
    end else if (sdv.gain_neg) begin
      if (quo > QUO_NEG_LIM) begin
        failm_d = 1'b1;
        m_d     = Q_MIN;
      end else begin
        m_d = ~quo[QW-1:0] + 1'b1;
      end
    end else if (quo > QUO_POS_LIM) begin
      failm_d = 1'b1;
      m_d     = Q_MAX;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else if (en) begin
      vm_q <= dv_v[DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sidem_q <= sdv;
      m_q     <= m_d;
      failm_q <= failm_d;
    end
  end

  // Product |mean| * |m|
  logic            vx_q;
  side_t           sidex_q;
  logic [QW-1:0]   mx_q;
  logic            failx_q;
  logic            negx_q;
  logic [2*QW-1:0] prodx_q;
  logic [QW-1:0]   mumag;
  logic [QW-1:0]   mmag;

  assign mumag = sidem_q.mean[QW-1] ? (~sidem_q.mean + 1'b1) : sidem_q.mean;
  assign mmag  = m_q[QW-1] ? (~m_q + 1'b1) : m_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vx_q <= 1'b0;
    end else if (en) begin
      vx_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sidex_q <= sidem_q;
      mx_q    <= m_q;
      failx_q <= failm_q;
      negx_q  <= sidem_q.mean[QW-1] ^ m_q[QW-1];
      prodx_q <= mumag * mmag;
    end
  end

  // Round back to Q16.16 and apply the sign
  logic            vr_q;
  side_t           sider_q;
  logic [QW-1:0]   mr_q;
  logic            failr_q;
  logic [47:0]     pr_q;
  logic [2*QW-1:0] rsum;
  logic [47:0]     pmag;

  assign rsum = prodx_q + 64'd32768;
  assign pmag = {1'b0, rsum[62:16]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= 1'b0;
    end else if (en) begin
      vr_q <= vx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sider_q <= sidex_q;
      mr_q    <= mx_q;
      failr_q <= failx_q;
      pr_q    <= negx_q ? (~pmag + 1'b1) : pmag;
    end
  end

  // Saturating subtract into the output register
  logic signed [48:0] diff;
  logic [QW-1:0]      a_d;
  logic               faila_d;

  assign diff = $signed({{17{sider_q.offset[QW-1]}}, sider_q.offset})
              - $signed({pr_q[47], pr_q});

  always_comb begin
    a_d     = diff[QW-1:0];
    faila_d = 1'b0;
    if (diff > $signed({17'd0, Q_MAX})) begin
      a_d     = Q_MAX;
      faila_d = 1'b1;
    end else if (diff < $signed({{17{1'b1}}, Q_MIN})) begin
      a_d     = Q_MIN;
      faila_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= vr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      multiplier_o <= mr_q;
      additive_o   <= a_d;
      status_o     <= failr_q | faila_d;
      result_tag_o <= sider_q.tag;
    end
  end

endmodule

`default_nettype wire

### hdl/bnf_checker.sv
// ----------------------------------------------------------------------------
// bnf_checker
// Port-level checks for batch_norm_affine_fold, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bnf_checker import bnf_pkg::*; (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 cfg_ready_o,
  input wire                 in_ready_o,
  input wire                 out_valid_o,
  input wire                 out_ready_i,
  input wire [QW-1:0]        multiplier_o,
  input wire [QW-1:0]        additive_o,
  input wire                 status_o,
  input wire [TAGW-1:0]      result_tag_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(multiplier_o)
      && $stable(additive_o) && $stable(status_o) && $stable(result_tag_o))
    else $error("output item changed while stalled");

  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  a_in_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input not ready while output drains");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind batch_norm_affine_fold bnf_checker u_bnf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cfg_ready_o  (cfg_ready_o),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .multiplier_o (multiplier_o),
  .additive_o   (additive_o),
  .status_o     (status_o),
  .result_tag_o (result_tag_o)
);

`default_nettype wire

### test/batch_norm_affine_fold_test.sv
// ----------------------------------------------------------------------------
// batch_norm_affine_fold_test
// Sends parameter sets to the batch-norm fold pipeline under random idling and
// a long output hold-off, predicts each multiplier/additive/status/tag and
// checks results in order. Epsilon is swept between phases, extremes included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module batch_norm_affine_fold_test;
  import bnf_pkg::*;

  localparam int unsigned LATENCY = 78;
  localparam longint      SAT_HI  = 64'sd2147483647;
  localparam longint      SAT_LO  = -64'sd2147483648;

  typedef struct packed {
    logic [QW-1:0]   multiplier;
    logic [QW-1:0]   additive;
    logic            status;
    logic [TAGW-1:0] tag;
  } fold_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [EPSW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [QW-1:0] gain_i = '0;
  logic signed [QW-1:0] offset_i = '0;
  logic signed [QW-1:0] running_mean_i = '0;
  logic [VARW-1:0] running_variance_i = '0;
  logic [TAGW-1:0] channel_tag_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [QW-1:0] multiplier_o;
  logic signed [QW-1:0] additive_o;
  logic status_o;
  logic [TAGW-1:0] result_tag_o;

  logic [EPSW-1:0] eps_model;
  fold_t pending_folds[$];
  int errors = 0;
  bit idle_enable = 1'b1;
  bit hold_off = 1'b0;
  int unsigned ready_idle = 0;

  batch_norm_affine_fold DUT (.*);

  always #4 clk_i = ~clk_i;

  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic fold_t fold_params(logic signed [QW-1:0] g, logic signed [QW-1:0] b,
                                        logic signed [QW-1:0] mu, logic [VARW-1:0] v,
                                        logic [TAGW-1:0] tag);
    fold_t f;
    logic [63:0] s, r, gmag, q, mm, mmul, p;
    longint m, a, prod;
    bit fail;
    fail = 0;
    s = 64'(v) + 64'(eps_model);
    if (s == 0) begin
      fail = 1;
      m = (g > 0) ? SAT_HI : ((g < 0) ? SAT_LO : 0);
    end else begin
      r = root64(s << 32);
      gmag = (g < 0) ? 64'(-longint'(g)) : 64'(longint'(g));
      q = ((gmag << 24) + (r >> 1)) / r;
      if (q > (64'd1 << 40)) q = 64'd1 << 40;
      m = (g < 0) ? -longint'(q) : longint'(q);
      if (m > SAT_HI) begin m = SAT_HI; fail = 1; end
      if (m < SAT_LO) begin m = SAT_LO; fail = 1; end
    end
    mm = (mu < 0) ? 64'(-longint'(mu)) : 64'(longint'(mu));
    mmul = (m < 0) ? 64'(-m) : 64'(m);
    p = (mm * mmul + 64'd32768) >> 16;
    prod = ((mu < 0) != (m < 0)) ? -longint'(p) : longint'(p);
    a = longint'(b) - prod;
    if (a > SAT_HI) begin a = SAT_HI; fail = 1; end
    if (a < SAT_LO) begin a = SAT_LO; fail = 1; end
    f.multiplier = m[31:0];
    f.additive = a[31:0];
    f.status = fail;
    f.tag = tag;
    return f;
  endfunction

  task automatic idle_burst();
    if (idle_enable && $urandom_range(3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  // valid stays high after an accept; the next item, an idle burst or drain()
  // decides what the input shows next
  task automatic send_params(logic [31:0] g, logic [31:0] b, logic [31:0] mu,
                             logic [VARW-1:0] v, logic [TAGW-1:0] tag);
    idle_burst();
    in_valid_i <= 1'b1;
    gain_i <= g;
    offset_i <= b;
    running_mean_i <= mu;
    running_variance_i <= v;
    channel_tag_i <= tag;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_folds.push_back(fold_params(g, b, mu, v, tag));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_folds.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_epsilon(logic [EPSW-1:0] eps);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= eps;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    eps_model = eps;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(int'($urandom_range(131072)) - 65536);
      3: return 32'(int'($urandom_range(1 << 24)) - (1 << 23));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [VARW-1:0] pick_variance();
    case ($urandom_range(4))
      0: return '0;
      1: return 31'h7FFF_FFFF;
      2: return VARW'($urandom_range(16));
      3: return VARW'($urandom_range(1 << 20));
      default: return VARW'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] ext[4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0001_0000};
    for (int i = 0; i < 4; i++)
      send_params(ext[i], ext[3 - i], ext[(i + 1) % 4], 31'h7FFF_FFFF, 16'hFFFF);
    write_epsilon(16'd0);
    send_params(32'h0001_0000, 32'h0, 32'h0001_0000, '0, 16'h0);
    send_params(32'hFFFF_0000, 32'h7FFF_FFFF, 32'h8000_0000, '0, 16'h1234);
    send_params(32'h0, 32'h8000_0000, 32'h7FFF_FFFF, '0, 16'hABCD);
    send_params(32'h7FFF_FFFF, 32'h0, 32'h0, 31'd1, 16'h5555);
    send_params(32'h8000_0000, 32'h0, 32'h0, 31'd1, 16'hAAAA);
    send_params(32'h0000_8000, 32'h1, 32'hFFFF_FFFF, 31'h0001_0000, 16'h0001);
    write_epsilon(16'hFFFF);
    send_params(32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, '0, 16'h8000);
    send_params(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 31'd1, 16'h7FFF);
    send_params(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h4000_0000, 16'h0F0F);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++)
      send_params(pick_word(), pick_word(), pick_word(), pick_variance(), 16'($urandom));
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      test_random(120);
      begin
        repeat (200) @(posedge clk_i);
        hold_off <= 1'b0;
      end
    join
  endtask

  // receiver idles in random bursts, each burst after a ready cycle
  always @(posedge clk_i) begin
    if (hold_off) begin
      out_ready_i <= 1'b0;
    end else if (ready_idle != 0) begin
      ready_idle <= ready_idle - 1;
      out_ready_i <= 1'b0;
    end else if (idle_enable && out_ready_i && $urandom_range(3) == 0) begin
      ready_idle <= $urandom_range(3);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    fold_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_folds.size() == 0) begin
        errors++;
        $display("%0t: unexpected result tag %h", $time, result_tag_o);
      end else begin
        want = pending_folds.pop_front();
        if (want.multiplier !== multiplier_o || want.additive !== additive_o ||
            want.status !== status_o || want.tag !== result_tag_o) begin
          errors++;
          $display("%0t: expected m=%h a=%h st=%b tag=%h, actual m=%h a=%h st=%b tag=%h",
                   $time, want.multiplier, want.additive, want.status, want.tag,
                   multiplier_o, additive_o, status_o, result_tag_o);
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    eps_model = EPS_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    write_epsilon(16'd1);
    test_random(200);
    test_backpressure();
    write_epsilon(16'd0);
    test_random(150);
    write_epsilon(16'h0100);
    test_random(150);
    idle_enable = 1'b0;
    test_random(120);
    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
